FILE: rtl/core/clcd_pkg.sv
// ----------------------------------------------------------------------------
// Character LCD expander writer package
// Shared types, register indexes and port byte constants for the writer.
// ----------------------------------------------------------------------------
package clcd_pkg;

    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes and widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT_ON = 2'd2;

    localparam logic [2:0] LINE_COUNT_RST   = 3'd4;
    localparam logic [5:0] COLUMN_COUNT_RST = 6'd20;
    localparam logic       BACKLIGHT_RST    = 1'b1;

    // Port byte bits
    localparam logic [7:0] PB_RS = 8'h01;
    localparam logic [7:0] PB_EN = 8'h04;
    localparam logic [7:0] PB_BL = 8'h08;

    // Controller commands
    localparam logic [7:0] CMD_FUNCSET = 8'h20;
    localparam logic [7:0] CMD_NBIT    = 8'h08;
    localparam logic [7:0] CMD_DDRAM   = 8'h80;

    typedef enum logic [1:0] {
        MODE_CHAR   = 2'd0,
        MODE_CMD    = 2'd1,
        MODE_NIBBLE = 2'd2,
        MODE_CURSOR = 2'd3
    } t_mode;

    // Nibble slots of one queued command: two data nibbles, then the
    // function set and DDRAM address bytes of a cursor move.
    localparam logic [2:0] SLOT_DATA_HI = 3'd0;
    localparam logic [2:0] SLOT_DATA_LO = 3'd1;
    localparam logic [2:0] SLOT_FS_HI   = 3'd2;
    localparam logic [2:0] SLOT_FS_LO   = 3'd3;
    localparam logic [2:0] SLOT_AD_HI   = 3'd4;
    localparam logic [2:0] SLOT_AD_LO   = 3'd5;

    // Strobe phases of one nibble
    localparam logic [1:0] PH_SETUP = 2'd0;
    localparam logic [1:0] PH_EN_HI = 2'd1;
    localparam logic [1:0] PH_EN_LO = 2'd2;

    typedef struct packed {
        logic       has_data;
        logic       half;
        logic       rs;
        logic [7:0] data;
        logic       has_cursor;
        logic [7:0] fs;
        logic [7:0] addr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [7:0] row_offset(input logic [1:0] row);
        logic [7:0] off;
        case (row)
            2'd0:    off = 8'h00;
            2'd1:    off = 8'h40;
            2'd2:    off = 8'h14;
            2'd3:    off = 8'h54;
            default: off = 8'h00;
        endcase
        return off;
    endfunction

endpackage

FILE: rtl/core/clcd_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one display request per transaction.
// ----------------------------------------------------------------------------
interface clcd_req_if import clcd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] value;
    logic [1:0] target_row;
    logic [5:0] target_column;

    modport source (output valid, mode, value, target_row, target_column, input ready);
    modport sink   (input valid, mode, value, target_row, target_column, output ready);
endinterface

FILE: rtl/core/clcd_port_if.sv
// ----------------------------------------------------------------------------
// Port byte channel
// Valid/ready channel that carries one expander byte per transaction.
// ----------------------------------------------------------------------------
interface clcd_port_if import clcd_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] port_byte;
    logic       last;

    modport source (output valid, port_byte, last, input ready);
    modport sink   (input valid, port_byte, last, output ready);
endinterface

FILE: rtl/core/clcd_front.sv
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, tracks the cursor and turns each request into a command.
// ----------------------------------------------------------------------------
module clcd_front import clcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clcd_req_if.sink   i_req,
    input  logic [2:0] i_line_count,
    input  logic [5:0] i_column_count,
    input  t_q_stat    i_q_stat,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [1:0] r_row, n_row;
    logic [5:0] r_col, n_col;

    logic [6:0] col_inc;
    logic       wrap;
    logic [1:0] last_row;
    logic [2:0] row_inc;
    logic [1:0] wrap_row;
    logic [7:0] fs;

    assign i_req.ready = !i_q_stat.full;
    assign o_push      = i_req.valid && i_req.ready;

    always_comb begin
        col_inc = {1'b0, r_col} + 7'd1;
        wrap    = col_inc >= {1'b0, i_column_count};
        if (i_line_count == 3'd0) begin
            last_row = 2'd0;
        end else if (i_line_count > 3'd4) begin
            last_row = 2'd3;
        end else begin
            last_row = 2'(i_line_count - 3'd1);
        end
        row_inc  = {1'b0, r_row} + 3'd1;
        wrap_row = (row_inc > {1'b0, last_row}) ? last_row : row_inc[1:0];
        fs       = CMD_FUNCSET | ((i_line_count >= 3'd2) ? CMD_NBIT : 8'h00);

        n_row = r_row;
        n_col = r_col;
        o_cmd = '0;
        o_cmd.fs   = fs;
        o_cmd.data = i_req.value;

        case (t_mode'(i_req.mode))
            MODE_CHAR: begin
                o_cmd.has_data = 1'b1;
                o_cmd.rs       = 1'b1;
                if (wrap) begin
                    n_row            = wrap_row;
                    n_col            = 6'd0;
                    o_cmd.has_cursor = 1'b1;
                    o_cmd.addr       = CMD_DDRAM | row_offset(wrap_row);
                end else begin
                    n_col = col_inc[5:0];
                end
            end
            MODE_CMD: begin
                o_cmd.has_data = 1'b1;
            end
            MODE_NIBBLE: begin
                o_cmd.has_data = 1'b1;
                o_cmd.half     = 1'b1;
            end
            MODE_CURSOR: begin
                n_row            = i_req.target_row;
                n_col            = i_req.target_column;
                o_cmd.has_cursor = 1'b1;
                o_cmd.addr       = CMD_DDRAM |
                                   (row_offset(i_req.target_row) + {2'b00, i_req.target_column});
            end
            default: begin
                o_cmd.has_data = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 2'd0;
            r_col <= 6'd0;
        end else if (o_push) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

FILE: rtl/core/clcd_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue of commands between front and back ends.
// ----------------------------------------------------------------------------
module clcd_fifo import clcd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
        return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
    endfunction

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == CntW'(DEPTH);
    assign o_stat.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/clcd_back.sv
// ----------------------------------------------------------------------------
// Port byte back end
// Expands queued commands into nibble strobes, one expander byte per cycle while the port is ready.
// ----------------------------------------------------------------------------
module clcd_back import clcd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_backlight_on,
    input  t_cmd       i_head,
    input  t_q_stat    i_q_stat,
    output logic       o_pop,
    clcd_port_if.source o_port
);

    logic       r_busy;
    t_cmd       r_cur;
    logic [2:0] r_slot;
    logic [1:0] r_phase;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic       adv;
    logic       final_slot;
    logic       end_of_cmd;
    logic [3:0] nib;
    logic       rs;
    logic [7:0] base;
    logic [7:0] pb;

    always_comb begin
        case (r_slot)
            SLOT_DATA_HI: nib = r_cur.data[7:4];
            SLOT_DATA_LO: nib = r_cur.data[3:0];
            SLOT_FS_HI:   nib = r_cur.fs[7:4];
            SLOT_FS_LO:   nib = r_cur.fs[3:0];
            SLOT_AD_HI:   nib = r_cur.addr[7:4];
            SLOT_AD_LO:   nib = r_cur.addr[3:0];
            default:      nib = 4'h0;
        endcase
        rs   = r_cur.rs && (r_slot == SLOT_DATA_HI || r_slot == SLOT_DATA_LO);
        base = {nib, 4'h0} | (i_backlight_on ? PB_BL : 8'h00) | (rs ? PB_RS : 8'h00);
        case (r_phase)
            PH_SETUP: pb = base;
            PH_EN_HI: pb = base | PB_EN;
            PH_EN_LO: pb = base & ~PB_EN;
            default:  pb = base;
        endcase
        final_slot = (r_slot == SLOT_AD_LO)
                  || (r_slot == SLOT_DATA_HI && r_cur.half)
                  || (r_slot == SLOT_DATA_LO && !r_cur.has_cursor);
        end_of_cmd = (r_phase == PH_EN_LO) && final_slot;
    end

    // The output register moves whenever it is empty or being taken.
    assign adv   = !r_out_valid || o_port.ready;
    assign o_pop = !i_q_stat.empty && (!r_busy || (adv && end_of_cmd));

    assign o_port.valid     = r_out_valid;
    assign o_port.port_byte = r_out_byte;
    assign o_port.last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_slot      <= SLOT_DATA_HI;
            r_phase     <= PH_SETUP;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy  <= 1'b1;
                r_slot  <= i_head.has_data ? SLOT_DATA_HI : SLOT_FS_HI;
                r_phase <= PH_SETUP;
            end else if (adv && r_busy) begin
                if (end_of_cmd) begin
                    r_busy <= 1'b0;
                end else if (r_phase == PH_EN_LO) begin
                    r_phase <= PH_SETUP;
                    r_slot  <= r_slot + 3'd1;
                end else begin
                    r_phase <= r_phase + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
        if (adv) begin
            r_out_byte <= pb;
            r_out_last <= end_of_cmd;
        end
    end

endmodule

FILE: rtl/core/char_lcd_nibble_expander_writer_unit.sv
// A request's command is written into the queue, then loaded into the back end's
// current command, and its strobe bytes leave through the output register.
// Throughput: one port byte per cycle while the port takes them; a request gives 3, 6,
// 12 or 18 port bytes. Requests queue ahead of the back end, so consecutive requests
// run without gaps. Reset (synchronous, active low) homes the cursor, empties the
// queue and loads four lines, twenty columns and backlight on.
// ----------------------------------------------------------------------------
// Character LCD nibble expander writer
// Turns display requests into 4-bit LCD strobe bytes for a port expander.
// ----------------------------------------------------------------------------
module char_lcd_nibble_expander_writer_unit import clcd_pkg::*; #(
    parameter int QueueDepth = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    clcd_req_if.sink              i_req,
    clcd_port_if.source           o_port
);

    logic [2:0] r_line_count;
    logic [5:0] r_column_count;
    logic       r_backlight_on;

    logic    push;
    logic    pop;
    t_cmd    cmd;
    t_cmd    head;
    t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count   <= LINE_COUNT_RST;
            r_column_count <= COLUMN_COUNT_RST;
            r_backlight_on <= BACKLIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LINE_COUNT:   r_line_count   <= i_cfg_data[2:0];
                CFG_COLUMN_COUNT: r_column_count <= i_cfg_data[5:0];
                CFG_BACKLIGHT_ON: r_backlight_on <= i_cfg_data[0];
                default:          r_line_count   <= r_line_count;
            endcase
        end
    end

    clcd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_line_count   (r_line_count),
        .i_column_count (r_column_count),
        .i_q_stat       (q_stat),
        .o_push         (push),
        .o_cmd          (cmd)
    );

    clcd_fifo #(
        .DEPTH (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    clcd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_backlight_on (r_backlight_on),
        .i_head         (head),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_port         (o_port)
    );

    // Reset leaves no port byte pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_port.valid)
        else $error("port byte valid after reset");

    // Every port byte carries the configured backlight and never drives bit 1.
    a_byte_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_port.valid |-> (o_port.port_byte[3] == r_backlight_on) && !o_port.port_byte[1])
        else $error("port byte has wrong fixed bits");

    // Bytes of one request follow each other without a gap.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_port.valid && o_port.ready && !o_port.last |=> o_port.valid)
        else $error("gap inside a request's byte sequence");

    // A queue that is empty and full at once means the count went wrong.
    a_q_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("command queue status inconsistent");

endmodule

FILE: verif/clcd_writer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD writer checker
// Watches the request, port byte and configuration traffic of the writer. It
// keeps its own copy of the display geometry and cursor, works out the strobe
// bytes that every accepted request must produce, and compares them in order.
// ----------------------------------------------------------------------------
module clcd_writer_checker import clcd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    clcd_req_if                   i_req,
    clcd_port_if                  i_port,
    output int                    o_error_count,
    output int                    o_pending_count
);

    localparam int PRINT_CAP = 100;

    // DDRAM start address of each display row
    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    typedef struct packed {
        logic [7:0] port_byte;
        logic       last;
    } t_port_beat;

    logic [2:0] line_count_cfg;
    logic [5:0] column_count_cfg;
    logic       backlight_cfg;
    logic [1:0] cur_row;
    logic [5:0] cur_col;

    t_port_beat expected_port_q[$];
    int         error_count = 0;

    assign o_error_count = error_count;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // One nibble is three expander writes: setup, enable high, enable low.
    task automatic queue_strobe_nibble(input logic [7:0] nib, input logic rs);
        logic [7:0] setup;
        setup = (nib & 8'hF0) | (rs ? PB_RS : 8'h00) | (backlight_cfg ? PB_BL : 8'h00);
        expected_port_q.push_back('{port_byte: setup, last: 1'b0});
        expected_port_q.push_back('{port_byte: setup | PB_EN, last: 1'b0});
        expected_port_q.push_back('{port_byte: setup & ~PB_EN, last: 1'b0});
    endtask

    task automatic queue_strobe_byte(input logic [7:0] b, input logic rs);
        queue_strobe_nibble(b & 8'hF0, rs);
        queue_strobe_nibble({b[3:0], 4'h0}, rs);
    endtask

    task automatic queue_cursor_move();
        logic [7:0] fs;
        logic [7:0] addr;
        fs = CMD_FUNCSET | ((line_count_cfg >= 3'd2) ? CMD_NBIT : 8'h00);
        // The 8-bit sum of row base and column stays below 256, so an off-screen column does not wrap.
        addr = CMD_DDRAM | (ROW_BASE[cur_row] + {2'b00, cur_col});
        queue_strobe_byte(fs, 1'b0);
        queue_strobe_byte(addr, 1'b0);
    endtask

    task automatic predict_request(input t_mode mode, input logic [7:0] value,
                                   input logic [1:0] row, input logic [5:0] col);
        logic [6:0] next_col;
        logic [2:0] bottom_row;
        logic [2:0] next_row;
        t_port_beat tail;
        case (mode)
            MODE_CHAR: begin
                queue_strobe_byte(value, 1'b1);
                next_col = {1'b0, cur_col} + 7'd1;
                if (next_col >= {1'b0, column_count_cfg}) begin
                    bottom_row = (line_count_cfg == 3'd0) ? 3'd0 : line_count_cfg - 3'd1;
                    if (bottom_row > 3'd3) bottom_row = 3'd3;
                    next_row = {1'b0, cur_row} + 3'd1;
                    if (next_row > bottom_row) next_row = bottom_row;
                    cur_row = next_row[1:0];
                    cur_col = 6'd0;
                    queue_cursor_move();
                end else begin
                    cur_col = next_col[5:0];
                end
            end
            MODE_CMD: begin
                queue_strobe_byte(value, 1'b0);
            end
            MODE_NIBBLE: begin
                queue_strobe_nibble(value & 8'hF0, 1'b0);
            end
            MODE_CURSOR: begin
                cur_row = row;
                cur_col = col;
                queue_cursor_move();
            end
            default: ;
        endcase
        tail = expected_port_q.pop_back();
        tail.last = 1'b1;
        expected_port_q.push_back(tail);
    endtask

    always @(posedge i_clk) begin
        t_port_beat want;
        if (!i_rst_n) begin
            line_count_cfg   = LINE_COUNT_RST;
            column_count_cfg = COLUMN_COUNT_RST;
            backlight_cfg    = BACKLIGHT_RST;
            cur_row          = 2'd0;
            cur_col          = 6'd0;
            expected_port_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LINE_COUNT:   line_count_cfg   = i_cfg_data[2:0];
                    CFG_COLUMN_COUNT: column_count_cfg = i_cfg_data[5:0];
                    CFG_BACKLIGHT_ON: backlight_cfg    = i_cfg_data[0];
                    default: ;
                endcase
            end
            // A port byte can never belong to a request accepted at the same edge.
            if (i_port.valid && i_port.ready) begin
                if (expected_port_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected port byte 0x%02h last %0b",
                                              i_port.port_byte, i_port.last));
                end else begin
                    want = expected_port_q.pop_front();
                    if (i_port.port_byte !== want.port_byte) begin
                        report_mismatch($sformatf("port_byte 0x%02h, expected 0x%02h",
                                                  i_port.port_byte, want.port_byte));
                    end
                    if (i_port.last !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b on byte 0x%02h",
                                                  i_port.last, want.last, want.port_byte));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                predict_request(t_mode'(i_req.mode), i_req.value,
                                i_req.target_row, i_req.target_column);
            end
        end
        o_pending_count <= expected_port_q.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Character LCD writer testbench
// Drives display requests and configuration changes into the writer, pulls
// its port bytes under several idle and stall patterns, and leaves checking
// of every byte to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    import clcd_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 8;
    localparam int ITEMS_PER_PHASE  = 27;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LINE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    int   sender_idle_pct = 0;
    int   receiver_stall_pct = 0;
    logic long_hold_armed = 1'b0;
    logic long_hold_done = 1'b0;
    int   hold_left = 0;

    clcd_req_if  req_ch();
    clcd_port_if port_ch();

    char_lcd_nibble_expander_writer_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch),
        .o_port      (port_ch)
    );

    clcd_writer_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_req           (req_ch),
        .i_port          (port_ch),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Port byte receiver. A one-time long hold-off lets the writer fill up
    // and push back on the request side.
    always @(posedge clk) begin
        if (long_hold_armed && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD_CYCLES;
            port_ch.ready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            port_ch.ready <= 1'b0;
        end else if ($urandom_range(99) < receiver_stall_pct) begin
            port_ch.ready <= 1'b0;
        end else begin
            port_ch.ready <= 1'b1;
        end
    end

    // Valid is left high after a transaction; the next call or the drain
    // decides its value, so it is never lowered and raised in one step.
    task automatic send_request(input t_mode mode, input logic [7:0] value,
                                input logic [1:0] row, input logic [5:0] col);
        while ($urandom_range(99) < sender_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= mode;
        req_ch.value         <= value;
        req_ch.target_row    <= row;
        req_ch.target_column <= col;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    task automatic send_random_request(input logic [5:0] columns);
        int         pick;
        t_mode      mode;
        logic [5:0] col;
        pick = $urandom_range(99);
        if (pick < 55)      mode = MODE_CHAR;
        else if (pick < 70) mode = MODE_CMD;
        else if (pick < 80) mode = MODE_NIBBLE;
        else                mode = MODE_CURSOR;
        // Cursor moves often land near the line end so that prints wrap.
        case ($urandom_range(3))
            0:       col = columns - 6'd1;
            1:       col = columns - 6'd2;
            default: col = 6'($urandom_range(63));
        endcase
        send_request(mode, 8'($urandom_range(255)), 2'($urandom_range(3)), col);
    endtask

    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_display_config(input logic [2:0] lines, input logic [5:0] columns,
                                        input logic backlight);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LINE_COUNT;
        cfg_data  <= {3'b000, lines};
        @(posedge clk);
        cfg_index <= CFG_COLUMN_COUNT;
        cfg_data  <= columns;
        @(posedge clk);
        cfg_index <= CFG_BACKLIGHT_ON;
        cfg_data  <= {5'b00000, backlight};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [2:0] lines, input logic [5:0] columns,
                                    input logic backlight, input t_idle_mode idle,
                                    input logic pressure);
        write_display_config(lines, columns, backlight);
        sender_idle_pct = (idle == IDLE_SENDER) ? 68 : (idle == IDLE_BOTH) ? 13 : 0;
        receiver_stall_pct <= (idle == IDLE_RECEIVER) ? 68 : (idle == IDLE_BOTH) ? 13 : 0;
        if (pressure) long_hold_armed <= 1'b1;
        repeat (ITEMS_PER_PHASE) send_random_request(columns);
        wait_until_drained();
    endtask

    initial begin
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_CHAR;
        req_ch.value         = 8'h00;
        req_ch.target_row    = 2'd0;
        req_ch.target_column = 6'd0;
        port_ch.ready        = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset geometry: four lines of twenty.
        send_request(MODE_CHAR,   8'h00, 2'd0, 6'd0);
        send_request(MODE_CHAR,   8'hFF, 2'd3, 6'd63);
        send_request(MODE_CMD,    8'h00, 2'd3, 6'd63);
        send_request(MODE_CMD,    8'hFF, 2'd0, 6'd0);
        send_request(MODE_NIBBLE, 8'hA5, 2'd2, 6'd21);
        send_request(MODE_NIBBLE, 8'h5A, 2'd1, 6'd42);
        send_request(MODE_CURSOR, 8'hFF, 2'd0, 6'd0);
        // Off-screen cursor; the next print starts from column 63 and wraps.
        send_request(MODE_CURSOR, 8'h00, 2'd3, 6'd63);
        send_request(MODE_CHAR,   8'h41, 2'd0, 6'd0);
        send_request(MODE_CURSOR, 8'h00, 2'd1, 6'd19);
        send_request(MODE_CHAR,   8'h42, 2'd0, 6'd0);
        send_request(MODE_CHAR,   8'h43, 2'd0, 6'd0);
        send_request(MODE_CURSOR, 8'h00, 2'd2, 6'd18);
        send_request(MODE_CHAR,   8'h44, 2'd0, 6'd0);
        send_request(MODE_CHAR,   8'h45, 2'd0, 6'd0);
        send_request(MODE_CURSOR, 8'h00, 2'd3, 6'd19);
        send_request(MODE_CHAR,   8'h46, 2'd0, 6'd0);
        send_request(MODE_CURSOR, 8'h00, 2'd0, 6'd40);
        send_request(MODE_CHAR,   8'h47, 2'd0, 6'd0);
        send_request(MODE_CMD,    8'h3C, 2'd0, 6'd0);
        wait_until_drained();

        run_random_phase(3'd1, 6'd1,  1'b0, IDLE_SENDER,   1'b0);
        run_random_phase(3'd2, 6'd16, 1'b1, IDLE_RECEIVER, 1'b0);
        // No columns and no lines: every print wraps onto row zero.
        run_random_phase(3'd0, 6'd0,  1'b1, IDLE_NONE,     1'b1);
        run_random_phase(3'd7, 6'd63, 1'b0, IDLE_BOTH,     1'b0);
        run_random_phase(3'd4, 6'd20, 1'b1, IDLE_NONE,     1'b0);
        run_random_phase(3'd3, 6'd52, 1'b0, IDLE_SENDER,   1'b0);

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
